// ----- rtl/ercme_pkg.sv -----
`default_nettype none
package ercme_pkg;

	typedef enum logic [1:0] {
		MODE_ENCODE = 2'd0,
		MODE_LOAD_SYM = 2'd1,
		MODE_LOAD_BKT = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	localparam logic KIND_RANGE = 1'b0;
	localparam logic KIND_RAW = 1'b1;

	// configuration register indexes
	localparam logic [2:0] REG_SYMBOL_TOTAL = 3'd0;
	localparam logic [2:0] REG_TRACKED = 3'd1;
	localparam logic [2:0] REG_BUCKET_WIDTH = 3'd2;
	localparam logic [2:0] REG_ESCAPE_BUCKET = 3'd3;
	localparam logic [2:0] REG_BUCKET_TOTAL = 3'd4;
	localparam logic [2:0] REG_AFTER_ZERO = 3'd5;
	localparam logic [2:0] REG_ZERO_AFTER_ZERO = 3'd6;

	localparam logic [31:0] AFTER_ZERO_DIVISOR = 32'd500;
	localparam logic [31:0] DEFAULT_ZERO_TOTAL = 32'd2;
	// ceil(2^37 / 125): x/500 == ((x >> 2) * AFTER_ZERO_RECIP) >> 37 for 32-bit x
	localparam logic [30:0] AFTER_ZERO_RECIP = 31'd1099511628;

	// one result transaction
	typedef struct packed {
		logic kind;
		logic [31:0] total;
		logic [31:0] base;
		logic [31:0] size;
		logic [31:0] bits;
		logic [5:0] width;
		logic last;
	} result_t;

	typedef struct packed {
		logic [31:0] symbol_total;
		logic [10:0] tracked;
		logic [5:0] bucket_width;
		logic [5:0] escape_bucket;
		logic [31:0] bucket_total;
		logic [31:0] after_zero_seen;
		logic [31:0] zero_after_zero_seen;
	} cfg_t;

endpackage
`default_nettype wire

// ----- rtl/ercme_ram.sv -----
`default_nettype none
module ercme_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1025
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/ercme_cfg.sv -----
`default_nettype none
module ercme_cfg
	import ercme_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output cfg_t cfg,
	output logic [31:0] zero_floor
);

	cfg_t cfg_q;
	logic [31:0] floor_q;
	logic [2:0] idx;
	logic wr;
	logic [60:0] floor_prod;

	assign idx = paddr[4:2];
	assign wr = psel && penable && pwrite;
	assign cfg = cfg_q;
	assign zero_floor = floor_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{32'd2, 11'd1024, 6'd2, 6'd1, 32'd20, 32'd0, 32'd0};
		end else if (wr) begin
			unique case (idx)
				REG_SYMBOL_TOTAL: cfg_q.symbol_total <= pwdata;
				REG_TRACKED: cfg_q.tracked <= pwdata[10:0];
				REG_BUCKET_WIDTH: cfg_q.bucket_width <= pwdata[5:0];
				REG_ESCAPE_BUCKET: cfg_q.escape_bucket <= pwdata[5:0];
				REG_BUCKET_TOTAL: cfg_q.bucket_total <= pwdata;
				REG_AFTER_ZERO: cfg_q.after_zero_seen <= pwdata;
				REG_ZERO_AFTER_ZERO: cfg_q.zero_after_zero_seen <= pwdata;
				default: ;
			endcase
		end
	end

	// after_zero_seen/500 as (x/4)/125 by reciprocal multiply (30 x 31 bits)
	assign floor_prod = cfg_q.after_zero_seen[31:2] * AFTER_ZERO_RECIP;

	// max(1, after_zero_seen/500), precomputed; the user must change the reg only while idle, not enforced here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= 32'd1;
		end else begin
			floor_q <= (cfg_q.after_zero_seen < AFTER_ZERO_DIVISOR) ? 32'd1
				: {8'd0, floor_prod[60:37]};
		end
	end

	// readback
	always_comb begin
		unique case (idx)
			REG_SYMBOL_TOTAL: prdata = cfg_q.symbol_total;
			REG_TRACKED: prdata = {21'd0, cfg_q.tracked};
			REG_BUCKET_WIDTH: prdata = {26'd0, cfg_q.bucket_width};
			REG_ESCAPE_BUCKET: prdata = {26'd0, cfg_q.escape_bucket};
			REG_BUCKET_TOTAL: prdata = cfg_q.bucket_total;
			REG_AFTER_ZERO: prdata = cfg_q.after_zero_seen;
			REG_ZERO_AFTER_ZERO: prdata = cfg_q.zero_after_zero_seen;
			default: prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/ercme_outq.sv -----
`default_nettype none
module ercme_outq
	import ercme_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire result_t push_data,
	output logic pop_valid,
	input wire logic pop,
	output result_t pop_data,
	output logic [$clog2(DEPTH):0] fill
);

	localparam int AW = $clog2(DEPTH);

	result_t mem [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;

	assign pop_valid = cnt_q != '0;
	assign pop_data = mem[rp_q];
	assign fill = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop && pop_valid) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop && pop_valid);
		end
	end

endmodule
`default_nettype wire

// ----- rtl/error_range_coder_model_encode_unit.sv -----
// Pipeline: an input transaction passes the stage 1, stage 2 and stage 3 registers, then the output queue.
// Throughput: an encode with n results (1 to 4) holds the last stage until all n are pushed,
// and the input waits meanwhile; loads and ignored modes pass at one per cycle when not stalled
// and give no result. A full output queue stalls the input.
// Reset: arst_n clears configuration to defaults and the pipeline; tables are
// undefined until loaded.
`default_nettype none
module error_range_coder_model_encode_unit
	import ercme_pkg::*;
#(
	parameter int SYMBOL_INDEX_BITS = 10,
	parameter int BUCKET_ENTRIES = 33
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic s_tvalid,
	output logic s_tready,
	// tdata: error_value[31:0], entry_index[42:32], entry_count[74:43], entry_base[106:75]
	input wire logic [111:0] s_tdata,
	// tuser: mode[1:0], prev_was_zero[2]
	input wire logic [2:0] s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// tdata: range_total[31:0], range_base[63:32], range_size[95:64],
	// raw_bits[127:96], raw_width[133:128]
	output logic [135:0] m_tdata,
	// tuser: result_kind
	output logic m_tuser,
	output logic m_tlast
);

	localparam int SYM_ENTRIES = (1 << SYMBOL_INDEX_BITS) + 1;
	localparam int SAW = $clog2(SYM_ENTRIES);
	localparam int BAW = $clog2(BUCKET_ENTRIES);
	localparam int QDEPTH = 32;
	localparam int QW = $clog2(QDEPTH);
	localparam logic [31:0] TRACK_MAX = 32'(1 << SYMBOL_INDEX_BITS);

	cfg_t cfg;
	logic [31:0] zero_floor;

	assign pready = 1'b1;

	ercme_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
		.cfg, .zero_floor
	);

	// input fields
	logic acc;
	logic [1:0] in_mode;
	logic [31:0] in_value, in_count, in_base;
	logic [10:0] in_index;
	logic in_pz;
	assign in_mode = s_tuser[1:0];
	assign in_pz = s_tuser[2];
	assign in_value = s_tdata[31:0];
	assign in_index = s_tdata[42:32];
	assign in_count = s_tdata[74:43];
	assign in_base = s_tdata[106:75];
	assign acc = s_tvalid && s_tready;

	// stage 1: zigzag, tracked test, bit length, zero triple
	logic v_s1, pz_s1, trk_s1, bld_s1;
	logic [31:0] val_s1, zz_s1, ztot_s1, zprob_s1, lcnt_s1, lbase_s1;
	logic [5:0] bits_s1;
	logic [BAW-1:0] bidx_s1;
	logic [31:0] zz_c, trk_c, prob_c, lim_c;
	logic [5:0] bits_c;
	logic [SAW-1:0] sidx_c;

	always_comb begin
		zz_c = {in_value[30:0], 1'b0} ^ {32{in_value[31]}};
		trk_c = ({21'd0, cfg.tracked} > TRACK_MAX) ? TRACK_MAX : {21'd0, cfg.tracked};
		bits_c = 6'd1;
		for (int i = 1; i < 32; i++) begin
			if (zz_c[i]) bits_c = 6'(i + 1);
		end
		sidx_c = (zz_c < trk_c) ? zz_c[SAW-1:0] : trk_c[SAW-1:0];
		lim_c = cfg.after_zero_seen - zero_floor;
		prob_c = (cfg.zero_after_zero_seen > lim_c) ? lim_c : cfg.zero_after_zero_seen;
	end

	// symbol table read port fed straight from the input
	logic sym_we, bkt_we, stall;
	logic [31:0] scnt_rd, sbase_rd, bcnt_rd, bbase_rd, ecnt_rd, ebase_rd;
	assign sym_we = acc && in_mode == MODE_LOAD_SYM && 32'(in_index) < 32'(SYM_ENTRIES);

	ercme_ram #(.WIDTH(32), .DEPTH(SYM_ENTRIES)) u_scnt (
		.clk, .we(sym_we), .waddr(SAW'(in_index)), .wdata(in_count),
		.re(!stall), .raddr(sidx_c), .rdata(scnt_rd));
	ercme_ram #(.WIDTH(32), .DEPTH(SYM_ENTRIES)) u_sbase (
		.clk, .we(sym_we), .waddr(SAW'(in_index)), .wdata(in_base),
		.re(!stall), .raddr(sidx_c), .rdata(sbase_rd));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			bld_s1 <= 1'b0;
		end else if (!stall) begin
			v_s1 <= acc && in_mode == MODE_ENCODE;
			bld_s1 <= acc && in_mode == MODE_LOAD_BKT
				&& 32'(in_index) < 32'(BUCKET_ENTRIES);
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			val_s1 <= in_value;
			zz_s1 <= zz_c;
			pz_s1 <= in_pz;
			trk_s1 <= zz_c < trk_c;
			bits_s1 <= bits_c;
			bidx_s1 <= BAW'(in_index);
			lcnt_s1 <= in_count;
			lbase_s1 <= in_base;
			if (cfg.after_zero_seen == 32'd0 || cfg.zero_after_zero_seen == 32'd0) begin
				ztot_s1 <= DEFAULT_ZERO_TOTAL;
				zprob_s1 <= 32'd1;
			end else begin
				ztot_s1 <= cfg.after_zero_seen;
				zprob_s1 <= prob_c;
			end
		end
	end

	// stage 2: bucket choice (small quotient by repeated compare on 6-bit values
	// replaced by a multiply compare: bucket = largest b with b*step<=bits-1)
	logic v_s2, pz_s2, trk_s2, bld_s2;
	logic [31:0] val_s2, zz_s2, ztot_s2, zprob_s2, scnt_s2, sbase_s2, lcnt_s2, lbase_s2;
	logic [5:0] bkt_s2, esc_s2, step_s2;
	logic [BAW-1:0] bidx_s2;
	logic [5:0] step_c, esc_c, bkt_c, bm1;

	always_comb begin
		step_c = (cfg.bucket_width == 6'd0) ? 6'd1 : cfg.bucket_width;
		esc_c = (32'(cfg.escape_bucket) >= 32'(BUCKET_ENTRIES))
			? 6'(BUCKET_ENTRIES - 1) : cfg.escape_bucket;
		bm1 = bits_s1 - 6'd1;
		bkt_c = '0;
		for (int b = 1; b < 32; b++) begin
			if (12'(b) * 12'(step_c) <= 12'(bm1)) bkt_c = 6'(b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			bld_s2 <= 1'b0;
		end else if (!stall) begin
			v_s2 <= v_s1;
			bld_s2 <= bld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			val_s2 <= val_s1;
			zz_s2 <= zz_s1;
			pz_s2 <= pz_s1;
			trk_s2 <= trk_s1;
			ztot_s2 <= ztot_s1;
			zprob_s2 <= zprob_s1;
			scnt_s2 <= scnt_rd;
			sbase_s2 <= sbase_rd;
			bkt_s2 <= bkt_c;
			esc_s2 <= esc_c;
			step_s2 <= step_c;
			bidx_s2 <= bidx_s1;
			lcnt_s2 <= lcnt_s1;
			lbase_s2 <= lbase_s1;
		end
	end

	// bucket loads write from stage 2, where encodes read, so program order holds
	assign bkt_we = bld_s2 && !stall;

	// bucket table reads: chosen bucket and escape bucket
	logic bkt_in;
	assign bkt_in = 32'(bkt_s2) < 32'(BUCKET_ENTRIES);

	ercme_ram #(.WIDTH(32), .DEPTH(BUCKET_ENTRIES)) u_bcnt (
		.clk, .we(bkt_we), .waddr(bidx_s2), .wdata(lcnt_s2),
		.re(!stall), .raddr(bkt_in ? bkt_s2[BAW-1:0] : '0), .rdata(bcnt_rd));
	ercme_ram #(.WIDTH(32), .DEPTH(BUCKET_ENTRIES)) u_bbase (
		.clk, .we(bkt_we), .waddr(bidx_s2), .wdata(lbase_s2),
		.re(!stall), .raddr(bkt_in ? bkt_s2[BAW-1:0] : '0), .rdata(bbase_rd));
	ercme_ram #(.WIDTH(32), .DEPTH(BUCKET_ENTRIES)) u_ecnt (
		.clk, .we(bkt_we), .waddr(bidx_s2), .wdata(lcnt_s2),
		.re(!stall), .raddr(esc_s2[BAW-1:0]), .rdata(ecnt_rd));
	ercme_ram #(.WIDTH(32), .DEPTH(BUCKET_ENTRIES)) u_ebase (
		.clk, .we(bkt_we), .waddr(bidx_s2), .wdata(lbase_s2),
		.re(!stall), .raddr(esc_s2[BAW-1:0]), .rdata(ebase_rd));

	// stage 3: hold item beside bucket read data, raw width
	logic v_s3, pz_s3, trk_s3, bin_s3, isesc_s3;
	logic [31:0] val_s3, zz_s3, ztot_s3, zprob_s3, scnt_s3, sbase_s3;
	logic [5:0] w_s3;
	logic [11:0] w_c;
	assign w_c = (12'(bkt_s2) + 12'd1) * 12'(step_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (!stall) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			val_s3 <= val_s2;
			zz_s3 <= zz_s2;
			pz_s3 <= pz_s2;
			trk_s3 <= trk_s2;
			ztot_s3 <= ztot_s2;
			zprob_s3 <= zprob_s2;
			scnt_s3 <= scnt_s2;
			sbase_s3 <= sbase_s2;
			bin_s3 <= bkt_in;
			isesc_s3 <= bkt_s2 == esc_s2;
			w_s3 <= (w_c > 12'd32) ? 6'd32 : w_c[5:0];
		end
	end

	// stage 4: build up to four results and push them into the queue
	result_t res [4];
	logic [2:0] nres;
	logic ok_c, empty_c;
	logic [31:0] bsz_c, bbs_c;

	always_comb begin
		empty_c = !bin_s3 || bcnt_rd == 32'd0;
		ok_c = !empty_c && !isesc_s3;
		bsz_c = empty_c ? ecnt_rd : bcnt_rd;
		bbs_c = empty_c ? ebase_rd : bbase_rd;
		for (int k = 0; k < 4; k++) res[k] = '0;
		nres = '0;
		if (pz_s3) begin
			res[0].total = ztot_s3;
			if (val_s3 == 32'd0) begin
				res[0].size = zprob_s3;
			end else begin
				res[0].base = zprob_s3;
				res[0].size = ztot_s3 - zprob_s3;
			end
			nres = 3'd1;
		end
		if (!(pz_s3 && val_s3 == 32'd0)) begin
			res[nres[1:0]].total = cfg.symbol_total;
			res[nres[1:0]].base = sbase_s3;
			res[nres[1:0]].size = scnt_s3;
			nres = nres + 3'd1;
			if (!trk_s3) begin
				res[nres[1:0]].total = cfg.bucket_total;
				res[nres[1:0]].base = bbs_c;
				res[nres[1:0]].size = bsz_c;
				nres = nres + 3'd1;
				res[nres[1:0]].kind = KIND_RAW;
				res[nres[1:0]].bits = ok_c ? zz_s3 : val_s3;
				res[nres[1:0]].width = ok_c ? w_s3 : 6'd32;
				nres = nres + 3'd1;
			end
		end
		res[nres[1:0] - 2'd1].last = 1'b1;
	end

	// serialize into the output queue one result per push, pausing while it is full
	logic [1:0] sub_q;
	logic push, item_done;
	logic [QW:0] fill;
	result_t q_out;
	logic qvalid;

	assign push = v_s3 && fill < (QW+1)'(QDEPTH);
	assign item_done = push && (3'(sub_q) + 3'd1 == nres);
	assign stall = v_s3 && !item_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= '0;
		end else if (item_done) begin
			sub_q <= '0;
		end else if (push) begin
			sub_q <= sub_q + 2'd1;
		end
	end

	ercme_outq #(.DEPTH(QDEPTH)) u_outq (
		.clk, .arst_n, .push, .push_data(res[sub_q]), .pop_valid(qvalid),
		.pop(m_tready), .pop_data(q_out), .fill);

	assign s_tready = !stall;
	assign m_tvalid = qvalid;
	assign m_tdata = {2'd0, q_out.width, q_out.bits, q_out.size, q_out.base, q_out.total};
	assign m_tuser = q_out.kind;
	assign m_tlast = q_out.last;

endmodule
`default_nettype wire

// ----- rtl/ercme_checker.sv -----
`default_nettype none
module ercme_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [135:0] m_tdata,
	input wire logic m_tuser,
	input wire logic m_tlast
);

	a_raw_width: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[133:128] <= 6'd32 && m_tdata[95:0] == 96'd0)
		else $error("raw result malformed");

	a_range_no_raw: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[133:96] == 38'd0)
		else $error("range result carries raw bits");

	a_raw_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("raw result not last");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind error_range_coder_model_encode_unit ercme_checker u_chk (
	.clk, .arst_n, .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
);
`default_nettype wire
